/* hw/rtl/midi_timecode_quarter_frame_decoder_top_assert.svh */
// Assertion macros for the time code quarter-frame decoder.
`ifndef MIDI_TIMECODE_QUARTER_FRAME_DECODER_TOP_ASSERT_SVH
`define MIDI_TIMECODE_QUARTER_FRAME_DECODER_TOP_ASSERT_SVH

// Invariant checked at every edge outside reset.
`define MTCQF_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("mtcqf invariant violated");

// Same-cycle implication.
`define MTCQF_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("mtcqf implication violated");

// Next-cycle implication.
`define MTCQF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("mtcqf next-cycle check violated");

`endif

/* hw/rtl/mtcqf_pkg.sv */
// Types and constants for the MIDI time code quarter-frame decoder.
package mtcqf_pkg;

    localparam int unsigned CFG_W = 16;
    localparam logic [CFG_W-1:0] LOCK_TIMEOUT_RST = 16'd30000;

    localparam logic [7:0] STATUS_QF = 8'hF1;

    // quarter-frame piece types (byte bits 6..4)
    localparam logic [2:0] PIECE_FRAME_LO  = 3'd0;
    localparam logic [2:0] PIECE_FRAME_HI  = 3'd1;
    localparam logic [2:0] PIECE_SEC_LO    = 3'd2;
    localparam logic [2:0] PIECE_SEC_HI    = 3'd3;
    localparam logic [2:0] PIECE_MIN_LO    = 3'd4;
    localparam logic [2:0] PIECE_MIN_HI    = 3'd5;
    localparam logic [2:0] PIECE_HOUR_LO   = 3'd6;
    localparam logic [2:0] PIECE_HOUR_RATE = 3'd7;

    typedef struct packed {
        logic       op;
        logic [7:0] rx_byte;
    } in_t;

    typedef struct packed {
        logic       locked;
        logic [2:0] rate_code;
        logic [7:0] frames;
        logic [5:0] seconds;
        logic [5:0] minutes;
        logic [4:0] hours;
        logic       full_cycle;
    } out_t;

    // decoder state, everything except the timeout counter
    typedef struct packed {
        logic       armed;
        logic       lock_flag;
        logic [1:0] start_count;
        logic [3:0] frame_lo;
        logic [4:0] frame_pend;
        logic [3:0] sec_lo;
        logic [5:0] sec_pend;
        logic [3:0] min_lo;
        logic [5:0] min_pend;
        logic [3:0] hour_lo;
        logic [1:0] rate_value;
        logic [7:0] frame_now;
        logic [5:0] sec_now;
        logic [5:0] min_now;
        logic [4:0] hour_now;
    } state_t;

endpackage

/* hw/rtl/mtcqf_decode.sv */
// Byte decoder: status arming and quarter-frame piece assembly.
module mtcqf_decode (
    input  mtcqf_pkg::in_t    beat,
    input  mtcqf_pkg::state_t st,
    output mtcqf_pkg::state_t st_next,
    output logic              timer_restart
);

    logic [2:0] kind;
    logic [3:0] nib;

    assign kind = beat.rx_byte[6:4];
    assign nib  = beat.rx_byte[3:0];

    always_comb begin
        st_next       = st;
        timer_restart = 1'b0;
        if (beat.op) begin
            if (beat.rx_byte == mtcqf_pkg::STATUS_QF) begin
                st_next.armed = 1'b1;
            end else if (st.armed) begin
                unique case (kind)
                    mtcqf_pkg::PIECE_FRAME_LO: begin
                        st_next.lock_flag   = 1'b1;
                        st_next.start_count = st.start_count + 2'd1;
                        st_next.frame_lo    = nib;
                        timer_restart       = 1'b1;
                    end
                    mtcqf_pkg::PIECE_FRAME_HI: begin
                        st_next.frame_pend = {nib[0], st.frame_lo};
                    end
                    mtcqf_pkg::PIECE_SEC_LO: begin
                        st_next.sec_lo = nib;
                    end
                    mtcqf_pkg::PIECE_SEC_HI: begin
                        st_next.sec_pend = {nib[1:0], st.sec_lo};
                    end
                    mtcqf_pkg::PIECE_MIN_LO: begin
                        st_next.min_lo    = nib;
                        st_next.frame_now = st.frame_now + 8'd1;
                    end
                    mtcqf_pkg::PIECE_MIN_HI: begin
                        st_next.min_pend = {nib[1:0], st.min_lo};
                    end
                    mtcqf_pkg::PIECE_HOUR_LO: begin
                        st_next.hour_lo = nib;
                    end
                    mtcqf_pkg::PIECE_HOUR_RATE: begin
                        // commit the assembled time
                        st_next.rate_value = nib[2:1];
                        st_next.hour_now   = {nib[0], st.hour_lo};
                        st_next.frame_now  = 8'(st.frame_pend);
                        st_next.sec_now    = st.sec_pend;
                        st_next.min_now    = st.min_pend;
                    end
                    default: begin
                        st_next = st;
                    end
                endcase
            end
        end
    end

endmodule

/* hw/rtl/midi_timecode_quarter_frame_decoder_top.sv */
// Top level of the MIDI time code quarter-frame decoder.
//
//  channel  ports                 direction  beat
//  cfg      cfg_wr_en/cfg_wr_data in         lock timeout write
//  s        s_valid/s_ready       in         one poll tick (op, rx_byte)
//  m        m_valid/m_ready       out        one status word per tick
//
//  Two stages: input register, then decode plus timeout counter into the
//  result register. One beat per cycle sustained while m is ready.
//  A stalled m side holds both stages; s_ready drops only when both are full.
//  aresetn (synchronous) clears all decoder state and loads timeout 30000.
module midi_timecode_quarter_frame_decoder_top #(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [mtcqf_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  mtcqf_pkg::in_t                s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output mtcqf_pkg::out_t               m_data
);

    localparam int unsigned CMP_W = (TIMER_WIDTH > mtcqf_pkg::CFG_W) ?
                                    TIMER_WIDTH : mtcqf_pkg::CFG_W;

    logic [mtcqf_pkg::CFG_W-1:0] lock_timeout_reg;

    logic              in_valid_reg;
    mtcqf_pkg::in_t    in_reg;
    logic              m_valid_reg;
    mtcqf_pkg::out_t   out_reg;

    mtcqf_pkg::state_t st_reg;
    mtcqf_pkg::state_t st_dec;
    mtcqf_pkg::state_t st_next;
    logic [TIMER_WIDTH-1:0] timer_reg;
    logic [TIMER_WIDTH-1:0] timer_dec;
    logic [TIMER_WIDTH-1:0] timer_next;
    logic                   timer_restart;

    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] timeout_ext;
    logic [CMP_W-1:0] timer_max;
    logic             full;
    mtcqf_pkg::out_t  out_next;

    logic advance;
    logic s_fire;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    mtcqf_decode u_decode (
        .beat          (in_reg),
        .st            (st_reg),
        .st_next       (st_dec),
        .timer_restart (timer_restart)
    );

    assign timeout_ext = CMP_W'(lock_timeout_reg);
    assign timer_max   = CMP_W'({TIMER_WIDTH{1'b1}});
    assign limit       = (timeout_ext < timer_max) ? timeout_ext : timer_max;
    assign timer_dec   = timer_restart ? '0 : timer_reg;

    always_comb begin
        st_next    = st_dec;
        timer_next = timer_dec;
        full       = 1'b0;
        if (CMP_W'(timer_dec) < limit) begin
            timer_next = timer_dec + TIMER_WIDTH'(1);
        end else begin
            st_next.lock_flag   = 1'b0;
            st_next.start_count = 2'd0;
        end
        // second frame start since lock: flag it and fold the count back
        if (st_next.start_count == 2'd2) begin
            st_next.start_count = 2'd1;
            full                = 1'b1;
        end

        out_next.locked     = st_next.lock_flag;
        out_next.rate_code  = st_next.lock_flag ? (3'(st_next.rate_value) + 3'd1) : 3'd0;
        out_next.frames     = st_next.frame_now;
        out_next.seconds    = st_next.sec_now;
        out_next.minutes    = st_next.min_now;
        out_next.hours      = st_next.hour_now;
        out_next.full_cycle = full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_timeout_reg <= mtcqf_pkg::LOCK_TIMEOUT_RST;
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            st_reg           <= '0;
            timer_reg        <= '0;
        end else begin
            if (cfg_wr_en) begin
                lock_timeout_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
                st_reg      <= st_next;
                timer_reg   <= timer_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg <= s_data;
        end
        if (advance) begin
            out_reg <= out_next;
        end
    end

    `include "midi_timecode_quarter_frame_decoder_top_assert.svh"

    `MTCQF_ASSERT_IMPLIES(a_rate_tracks_lock, m_valid_reg, (out_reg.rate_code != 3'd0) == out_reg.locked)
    `MTCQF_ASSERT_IMPLIES(a_full_needs_lock, m_valid_reg && out_reg.full_cycle, out_reg.locked)
    `MTCQF_ASSERT_ALWAYS(a_count_folded, st_reg.start_count != 2'd2 && st_reg.start_count != 2'd3)
    `MTCQF_ASSERT_IMPLIES(a_unlocked_no_starts, !st_reg.lock_flag, st_reg.start_count == 2'd0)
    `MTCQF_ASSERT_NEXT(a_tick_reaches_output, advance, m_valid_reg)

endmodule

/* verif/mtcqf_status_checker.sv */
// Status word checker for the quarter-frame decoder: predicts each word and compares it.
`timescale 1ns / 1ps
module mtcqf_status_checker
    import mtcqf_pkg::*;
#(
    parameter int unsigned TIMER_WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_t              s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_t             m_data,
    output int               errors,
    output int               words_owed
);
    localparam longint unsigned TICK_MAX = (64'd1 << TIMER_WIDTH) - 64'd1;

    logic [CFG_W-1:0] lock_timeout;
    state_t           tc;
    longint unsigned  lock_ticks;
    out_t             status_words_q[$];

    // One poll tick through the decoder; updates the shadow state.
    function automatic out_t decode_tick(in_t beat);
        logic [3:0]      nib;
        longint unsigned limit;
        out_t            word;
        nib = beat.rx_byte[3:0];
        if (beat.op) begin
            if (beat.rx_byte == STATUS_QF) begin
                tc.armed = 1'b1;
            end else if (tc.armed) begin
                // bit 7 plays no part once armed
                case (beat.rx_byte[6:4])
                    PIECE_FRAME_LO: begin
                        tc.lock_flag   = 1'b1;
                        tc.start_count = tc.start_count + 2'd1;
                        lock_ticks     = 0;
                        tc.frame_lo    = nib;
                    end
                    PIECE_FRAME_HI: tc.frame_pend = {nib[0], tc.frame_lo};
                    PIECE_SEC_LO:   tc.sec_lo = nib;
                    PIECE_SEC_HI:   tc.sec_pend = {nib[1:0], tc.sec_lo};
                    PIECE_MIN_LO: begin
                        tc.min_lo    = nib;
                        tc.frame_now = tc.frame_now + 8'd1;
                    end
                    PIECE_MIN_HI:   tc.min_pend = {nib[1:0], tc.min_lo};
                    PIECE_HOUR_LO:  tc.hour_lo = nib;
                    default: begin
                        tc.rate_value = nib[2:1];
                        tc.frame_now  = {3'b000, tc.frame_pend};
                        tc.sec_now    = tc.sec_pend;
                        tc.min_now    = tc.min_pend;
                        tc.hour_now   = {nib[0], tc.hour_lo};
                    end
                endcase
            end
        end
        limit = (lock_timeout > TICK_MAX) ? TICK_MAX : lock_timeout;
        if (lock_ticks < limit) begin
            lock_ticks = (lock_ticks + 1) & TICK_MAX;
        end else begin
            tc.lock_flag   = 1'b0;
            tc.start_count = 2'd0;
        end
        word.full_cycle = (tc.start_count == 2'd2);
        if (word.full_cycle) begin
            tc.start_count = 2'd1;
        end
        word.locked    = tc.lock_flag;
        word.rate_code = tc.lock_flag ? {1'b0, tc.rate_value} + 3'd1 : 3'd0;
        word.frames    = tc.frame_now;
        word.seconds   = tc.sec_now;
        word.minutes   = tc.min_now;
        word.hours     = tc.hour_now;
        return word;
    endfunction

    always @(posedge aclk) begin
        out_t want;
        if (!aresetn) begin
            lock_timeout = LOCK_TIMEOUT_RST;
            tc           = '0;
            lock_ticks   = 0;
            status_words_q.delete();
        end else begin
            if (cfg_wr_en) begin
                lock_timeout = cfg_wr_data;
            end
            if (m_valid && m_ready) begin
                if (status_words_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: status beat with nothing outstanding: %h", $realtime, m_data);
                    end
                end else begin
                    want = status_words_q.pop_front();
                    if (m_data.locked !== want.locked || m_data.rate_code !== want.rate_code ||
                        m_data.frames !== want.frames || m_data.seconds !== want.seconds ||
                        m_data.minutes !== want.minutes || m_data.hours !== want.hours ||
                        m_data.full_cycle !== want.full_cycle) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: status mismatch exp lk %0d rc %0d f %0d s %0d m %0d h %0d fc %0d",
                                     $realtime, want.locked, want.rate_code, want.frames,
                                     want.seconds, want.minutes, want.hours, want.full_cycle);
                            $display("%0t:                 got lk %0d rc %0d f %0d s %0d m %0d h %0d fc %0d",
                                     $realtime, m_data.locked, m_data.rate_code, m_data.frames,
                                     m_data.seconds, m_data.minutes, m_data.hours,
                                     m_data.full_cycle);
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                status_words_q.push_back(decode_tick(s_data));
            end
        end
        words_owed = status_words_q.size();
    end

endmodule

/* verif/midi_timecode_quarter_frame_decoder_top_tb.sv */
// Testbench top for the quarter-frame decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module midi_timecode_quarter_frame_decoder_top_tb;
    import mtcqf_pkg::*;

    localparam int unsigned TIMER_WIDTH = 16;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          PHASES = 8;
    localparam int          TICKS_PER_PHASE = 170;
    localparam int          DIRECTED_TICKS = 24;
    localparam logic        OP_TICK = 1'b0;
    localparam logic        OP_BYTE = 1'b1;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SINK, IDLE_BOTH} idle_mode_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    in_t              s_data;
    logic             m_valid;
    logic             m_ready;
    out_t             m_data;

    int         errors;
    int         words_owed;
    int         cycles;
    int         ticks_sent;
    idle_mode_t idle_mode;

    // phase 0 runs on the reset timeout
    logic [CFG_W-1:0] phase_timeout [PHASES] = '{16'd30000, 16'd1, 16'd0, 16'd65535,
                                                 16'd4, 16'd37, 16'd2, 16'd300};

    // {op, byte}: ignored bytes, arming, all pieces at both nibble extremes,
    // status-range pieces, repeated frame starts
    logic [8:0] directed [DIRECTED_TICKS] = '{
        {OP_TICK, 8'hFF}, {OP_TICK, STATUS_QF}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'h7F},
        {OP_BYTE, STATUS_QF},
        {OP_BYTE, 8'h0F}, {OP_BYTE, 8'h1F}, {OP_BYTE, 8'h2F}, {OP_BYTE, 8'h3F},
        {OP_BYTE, 8'h4F}, {OP_BYTE, 8'h5F}, {OP_BYTE, 8'h6F}, {OP_BYTE, 8'h7F},
        {OP_BYTE, STATUS_QF},
        {OP_BYTE, 8'h80}, {OP_BYTE, 8'h90}, {OP_BYTE, 8'hA0}, {OP_BYTE, 8'hB0},
        {OP_BYTE, 8'hC0}, {OP_BYTE, 8'hD0}, {OP_BYTE, 8'hE0}, {OP_BYTE, 8'hF0},
        {OP_BYTE, 8'h80}, {OP_TICK, 8'h00}
    };

    midi_timecode_quarter_frame_decoder_top #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    mtcqf_status_checker #(
        .TIMER_WIDTH(TIMER_WIDTH)
    ) u_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .errors     (errors),
        .words_owed (words_owed)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("midi_timecode_quarter_frame_decoder_top_tb: errors");
            $finish;
        end
    end

    function automatic int src_idle_pct();
        return (idle_mode == IDLE_SRC) ? 72 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    endfunction

    function automatic int sink_stall_pct();
        return (idle_mode == IDLE_SINK) ? 72 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    endfunction

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct());
    end

    // One beat on the s side, with a random idle gap ahead of it.
    task automatic send_tick(input logic with_byte, input logic [7:0] rx);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct()) gap++;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{op: with_byte, rx_byte: rx};
        do @(posedge aclk); while (!s_ready);
        ticks_sent++;
    endtask

    function automatic logic [7:0] piece_byte(input logic [2:0] kind);
        logic [7:0] b;
        b = {1'b0, kind, 4'($urandom_range(15))};
        if ($urandom_range(7) == 0) begin
            b[7] = 1'b1;
        end
        return b;
    endfunction

    // All eight pieces in order, optionally each behind a status byte.
    task automatic send_frame();
        bit with_status;
        with_status = 1'($urandom_range(1));
        for (int k = 0; k < 8; k++) begin
            if (with_status) begin
                send_tick(OP_BYTE, STATUS_QF);
            end
            send_tick(OP_BYTE, piece_byte(3'(k)));
            if ($urandom_range(3) == 0) begin
                send_tick(OP_TICK, 8'($urandom_range(255)));
            end
        end
    endtask

    task automatic send_broken();
        int n;
        n = $urandom_range(2, 9);
        repeat (n) begin
            if ($urandom_range(5) == 0) begin
                send_tick(OP_BYTE, STATUS_QF);
            end else begin
                send_tick(OP_BYTE, piece_byte(3'($urandom_range(7))));
            end
        end
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(4, 8);
        repeat (n) send_tick(1'($urandom_range(1)), 8'($urandom_range(255)));
    endtask

    task automatic send_quiet();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) send_tick(OP_TICK, 8'($urandom_range(255)));
    endtask

    initial begin
        int phase_start;
        int pick;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        idle_mode   = IDLE_NONE;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                foreach (directed[i]) send_tick(directed[i][8], directed[i][7:0]);
                // last directed beat is taken; stop offering it
                @(negedge aclk);
                s_valid <= 1'b0;
            end else begin
                // drain, then load the new timeout while the decoder is quiet
                @(negedge aclk);
                s_valid <= 1'b0;
                while (words_owed != 0) @(negedge aclk);
                repeat (4) @(negedge aclk);
                cfg_wr_en   <= 1'b1;
                cfg_wr_data <= phase_timeout[p];
                @(negedge aclk);
                cfg_wr_en <= 1'b0;
            end
            @(posedge aclk);
            idle_mode = idle_mode_t'(p % 4);
            if (p == 3) begin
                // run the live frame number through its 8-bit wrap
                repeat (260) send_tick(OP_BYTE, {1'b0, PIECE_MIN_LO, 4'($urandom_range(15))});
            end
            phase_start = ticks_sent;
            while (ticks_sent - phase_start < TICKS_PER_PHASE) begin
                pick = $urandom_range(99);
                if (pick < 65) begin
                    send_frame();
                end else if (pick < 80) begin
                    send_broken();
                end else if (pick < 90) begin
                    send_noise();
                end else begin
                    send_quiet();
                end
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (words_owed != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("midi_timecode_quarter_frame_decoder_top_tb: clean");
        end else begin
            $display("midi_timecode_quarter_frame_decoder_top_tb: errors");
        end
        $finish;
    end

endmodule
